// ===== rtl/mes_pkg.sv =====
// Shared types, constants and stage tables for the sketch update block.
package mes_pkg;

	// Table depths
	localparam int ONE_DEPTH   = 8192;
	localparam int TWO_DEPTH   = 8192;
	localparam int THREE_DEPTH = 4096;
	localparam int LIGHT_DEPTH = 16384;

	localparam int ONE_AW   = $clog2(ONE_DEPTH);
	localparam int TWO_AW   = $clog2(TWO_DEPTH);
	localparam int THREE_AW = $clog2(THREE_DEPTH);
	localparam int LIGHT_AW = $clog2(LIGHT_DEPTH);

	// Largest table sets the clear sweep and the shared address width
	localparam int MAX_HEAVY = (ONE_DEPTH > TWO_DEPTH) ?
		((ONE_DEPTH > THREE_DEPTH) ? ONE_DEPTH : THREE_DEPTH) :
		((TWO_DEPTH > THREE_DEPTH) ? TWO_DEPTH : THREE_DEPTH);
	localparam int CLR_DEPTH = (MAX_HEAVY > LIGHT_DEPTH) ? MAX_HEAVY : LIGHT_DEPTH;
	localparam int AW_MAX    = $clog2(CLR_DEPTH);

	// Hash multipliers and index extraction
	localparam logic [31:0] MULT_ONE   = 32'h04C1_1DB7;
	localparam logic [31:0] MULT_TWO   = 32'h1EDC_6F41;
	localparam logic [31:0] MULT_THREE = 32'hA833_982B;
	localparam logic [31:0] MULT_LIGHT = 32'h8141_41AB;
	localparam int INDEX_SHIFT = 15;
	localparam int RAW_W       = 32 - INDEX_SHIFT;

	// Reciprocals for the modulo by table depth: q = (raw * R) >> RECIP_SHIFT
	localparam int RECIP_SHIFT = 2 * RAW_W;
	localparam logic [31:0] ONE_RECIP = 32'(((64'd1 << RECIP_SHIFT) +
		64'(ONE_DEPTH) - 64'd1) / 64'(ONE_DEPTH));
	localparam logic [31:0] TWO_RECIP = 32'(((64'd1 << RECIP_SHIFT) +
		64'(TWO_DEPTH) - 64'd1) / 64'(TWO_DEPTH));
	localparam logic [31:0] THREE_RECIP = 32'(((64'd1 << RECIP_SHIFT) +
		64'(THREE_DEPTH) - 64'd1) / 64'(THREE_DEPTH));
	localparam logic [31:0] LIGHT_RECIP = 32'(((64'd1 << RECIP_SHIFT) +
		64'(LIGHT_DEPTH) - 64'd1) / 64'(LIGHT_DEPTH));

	localparam logic [15:0] RATIO_RESET = 16'd8;

	// Stage codes, equal to the reported place
	localparam logic [1:0] STG_ONE   = 2'd0;
	localparam logic [1:0] STG_TWO   = 2'd1;
	localparam logic [1:0] STG_THREE = 2'd2;
	localparam logic [1:0] STG_LIGHT = 2'd3;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] pos;
		logic [31:0] neg;
	} slot_t;

	// Memory access from the sequencer
	typedef struct packed {
		logic              clr;
		logic [1:0]        stg;
		logic [AW_MAX-1:0] addr;
		logic              we;
		slot_t             wslot;
		logic [7:0]        wlight;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]  place;
		logic [1:0]  swaps;
		logic [31:0] spill_key;
		logic [31:0] spill_count;
		logic [7:0]  light;
	} res_t;

	function automatic logic [31:0] stg_mult(input logic [1:0] s);
		case (s)
			STG_ONE:   return MULT_ONE;
			STG_TWO:   return MULT_TWO;
			STG_THREE: return MULT_THREE;
			default:   return MULT_LIGHT;
		endcase
	endfunction

	function automatic logic [31:0] stg_recip(input logic [1:0] s);
		case (s)
			STG_ONE:   return ONE_RECIP;
			STG_TWO:   return TWO_RECIP;
			STG_THREE: return THREE_RECIP;
			default:   return LIGHT_RECIP;
		endcase
	endfunction

	function automatic logic [31:0] stg_depth(input logic [1:0] s);
		case (s)
			STG_ONE:   return 32'(ONE_DEPTH);
			STG_TWO:   return 32'(TWO_DEPTH);
			STG_THREE: return 32'(THREE_DEPTH);
			default:   return 32'(LIGHT_DEPTH);
		endcase
	endfunction

endpackage

// ===== rtl/mes_ram.sv =====
// Simple dual-port RAM with registered read data.
module mes_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mes_mul.sv =====
// Shared 32x32 multiplier with a registered 64-bit product.
module mes_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	// Register the full product
	always_ff @(posedge clk) begin
		p <= 64'(a) * 64'(b);
	end

endmodule

// ===== rtl/mes_seq.sv =====
// Sequencer and datapath: hash, index, probe and update one stage at a time.
module mes_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          flow_key,
	input  logic [15:0]          ratio,
	output logic                 busy,
	output mes_pkg::mem_req_t    req,
	input  mes_pkg::slot_t       rd_slot,
	input  logic [7:0]           rd_light,
	output logic [31:0]          mul_a,
	output logic [31:0]          mul_b,
	input  logic [63:0]          mul_p,
	output logic                 done,
	output mes_pkg::res_t        res
);

	import mes_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_HASH  = 4'd2;
	localparam logic [3:0] S_RECIP = 4'd3;
	localparam logic [3:0] S_SCALE = 4'd4;
	localparam logic [3:0] S_INDEX = 4'd5;
	localparam logic [3:0] S_READ  = 4'd6;
	localparam logic [3:0] S_EVAL  = 4'd7;
	localparam logic [3:0] S_CMP   = 4'd8;

	logic [3:0]        state_q;
	logic [1:0]        stg_q;
	logic [AW_MAX-1:0] idx_q;
	logic [1:0]        swaps_q;
	logic              done_q;
	logic [31:0]       key_q;
	logic [31:0]       cnt_q;
	logic [RAW_W-1:0]  raw_q;
	logic [31:0]       negn_q;
	res_t              res_q;

	logic [RAW_W-1:0]  raw_c;
	logic [RAW_W-1:0]  rem_c;
	logic              is_empty;
	logic              is_match;
	logic              replace;
	logic [7:0]        light_new;
	logic [31:0]       pos_sum;
	logic [31:0]       neg_sum;

	function automatic logic [31:0] sat_add(input logic [31:0] x, input logic [31:0] y);
		logic [32:0] s;
		s = 33'(x) + 33'(y);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Decode products and the probed slot
	assign raw_c     = mul_p[INDEX_SHIFT +: RAW_W];
	assign rem_c     = raw_q - mul_p[RAW_W-1:0];
	assign is_empty  = (rd_slot.key == 32'd0);
	assign is_match  = (rd_slot.key == key_q);
	assign light_new = rd_light + cnt_q[7:0];
	assign pos_sum   = sat_add(rd_slot.pos, cnt_q);
	assign neg_sum   = sat_add(rd_slot.neg, cnt_q);
	assign replace   = ({16'd0, negn_q} >= mul_p[47:0]);

	// Drive the shared multiplier and the memory request
	always_comb begin
		mul_a       = 32'd0;
		mul_b       = 32'd0;
		req.clr     = 1'b0;
		req.stg     = stg_q;
		req.addr    = idx_q;
		req.we      = 1'b0;
		req.wslot   = '0;
		req.wlight  = 8'd0;
		case (state_q)
			S_CLR: begin
				req.clr = 1'b1;
				req.we  = 1'b1;
			end
			S_HASH: begin
				mul_a = key_q;
				mul_b = stg_mult(stg_q);
			end
			S_RECIP: begin
				mul_a = 32'(raw_c);
				mul_b = stg_recip(stg_q);
			end
			S_SCALE: begin
				mul_a = 32'(mul_p[63:RECIP_SHIFT]);
				mul_b = stg_depth(stg_q);
			end
			S_EVAL: begin
				if (stg_q == STG_LIGHT) begin
					req.we     = 1'b1;
					req.wlight = light_new;
				end else if (is_empty) begin
					req.we    = 1'b1;
					req.wslot = '{key: key_q, pos: cnt_q, neg: rd_slot.neg};
				end else if (is_match) begin
					req.we    = 1'b1;
					req.wslot = '{key: rd_slot.key, pos: pos_sum, neg: rd_slot.neg};
				end else begin
					mul_a = rd_slot.pos;
					mul_b = 32'(ratio);
				end
			end
			S_CMP: begin
				req.we = 1'b1;
				if (replace) begin
					req.wslot = '{key: key_q, pos: cnt_q, neg: 32'd0};
				end else begin
					req.wslot = '{key: rd_slot.key, pos: rd_slot.pos, neg: negn_q};
				end
			end
			default: begin
			end
		endcase
	end

	// Advance the sequencer; sweep the tables after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			stg_q   <= STG_ONE;
			idx_q   <= '0;
			swaps_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == AW_MAX'(CLR_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						stg_q   <= STG_ONE;
						swaps_q <= 2'd0;
						state_q <= S_HASH;
					end
				end
				S_HASH:  state_q <= S_RECIP;
				S_RECIP: state_q <= S_SCALE;
				S_SCALE: state_q <= S_INDEX;
				S_INDEX: begin
					idx_q   <= rem_c[AW_MAX-1:0];
					state_q <= S_READ;
				end
				S_READ:  state_q <= S_EVAL;
				S_EVAL: begin
					if (stg_q == STG_LIGHT || is_empty || is_match) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (replace) begin
						swaps_q <= swaps_q + 1'b1;
					end
					stg_q   <= stg_q + 1'b1;
					state_q <= S_HASH;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the moving pair and the result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q <= flow_key;
				cnt_q <= 32'd1;
			end
			S_RECIP: raw_q <= raw_c;
			S_EVAL: begin
				negn_q <= neg_sum;
				res_q.place       <= stg_q;
				res_q.swaps       <= swaps_q;
				res_q.spill_key   <= (stg_q == STG_LIGHT) ? key_q : 32'd0;
				res_q.spill_count <= (stg_q == STG_LIGHT) ? cnt_q : 32'd0;
				res_q.light       <= (stg_q == STG_LIGHT) ? light_new : 8'd0;
			end
			S_CMP: begin
				if (replace) begin
					key_q <= rd_slot.key;
					cnt_q <= rd_slot.pos;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/multi_stage_elastic_sketch_update.sv =====
// Top level: tables, shared multiplier, sequencer and ratio register.
//
// After reset the block sweeps all tables to zero, one entry per cycle
// for the depth of the largest table, with busy high; ratio writes are
// taken at any time. A transaction is accepted when start is high and
// busy is low. Each stage probe runs through the one shared multiplier
// (hash, reciprocal, depth scale) and a registered table read, plus a
// ratio product and a compare step when the pair moves on; busy stays
// high until the pair comes to rest. The result appears as busy falls,
// with done high for exactly one cycle; the receiver cannot stall it, and
// a new transaction may start in that same cycle.
module multi_stage_elastic_sketch_update (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] flow_key,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [1:0]  place,
	output logic [1:0]  swap_count,
	output logic [31:0] spill_key,
	output logic [31:0] spill_count,
	output logic [7:0]  light_value
);

	import mes_pkg::*;

	logic [15:0] ratio_q;
	mem_req_t    req;
	slot_t       rd_slot;
	slot_t       rd_one;
	slot_t       rd_two;
	slot_t       rd_three;
	logic [7:0]  rd_light;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	res_t        res;
	logic        we_one;
	logic        we_two;
	logic        we_three;
	logic        we_light;

	// Ratio register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ratio_q <= cfg_data;
		end
	end

	// Steer writes: the clear sweep hits every table within its depth
	assign we_one   = req.we && (req.clr || req.stg == STG_ONE) &&
		({1'b0, req.addr} < (AW_MAX + 1)'(ONE_DEPTH));
	assign we_two   = req.we && (req.clr || req.stg == STG_TWO) &&
		({1'b0, req.addr} < (AW_MAX + 1)'(TWO_DEPTH));
	assign we_three = req.we && (req.clr || req.stg == STG_THREE) &&
		({1'b0, req.addr} < (AW_MAX + 1)'(THREE_DEPTH));
	assign we_light = req.we && (req.clr || req.stg == STG_LIGHT) &&
		({1'b0, req.addr} < (AW_MAX + 1)'(LIGHT_DEPTH));

	mes_ram #(.DEPTH(ONE_DEPTH), .WIDTH($bits(slot_t))) u_ram_one (
		.clk   (clk),
		.we    (we_one),
		.waddr (req.addr[ONE_AW-1:0]),
		.wdata (req.wslot),
		.raddr (req.addr[ONE_AW-1:0]),
		.rdata (rd_one)
	);

	mes_ram #(.DEPTH(TWO_DEPTH), .WIDTH($bits(slot_t))) u_ram_two (
		.clk   (clk),
		.we    (we_two),
		.waddr (req.addr[TWO_AW-1:0]),
		.wdata (req.wslot),
		.raddr (req.addr[TWO_AW-1:0]),
		.rdata (rd_two)
	);

	mes_ram #(.DEPTH(THREE_DEPTH), .WIDTH($bits(slot_t))) u_ram_three (
		.clk   (clk),
		.we    (we_three),
		.waddr (req.addr[THREE_AW-1:0]),
		.wdata (req.wslot),
		.raddr (req.addr[THREE_AW-1:0]),
		.rdata (rd_three)
	);

	mes_ram #(.DEPTH(LIGHT_DEPTH), .WIDTH(8)) u_ram_light (
		.clk   (clk),
		.we    (we_light),
		.waddr (req.addr[LIGHT_AW-1:0]),
		.wdata (req.wlight),
		.raddr (req.addr[LIGHT_AW-1:0]),
		.rdata (rd_light)
	);

	// Select the probed heavy slot
	always_comb begin
		case (req.stg)
			STG_ONE:   rd_slot = rd_one;
			STG_TWO:   rd_slot = rd_two;
			default:   rd_slot = rd_three;
		endcase
	end

	mes_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	mes_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.flow_key (flow_key),
		.ratio    (ratio_q),
		.busy     (busy),
		.req      (req),
		.rd_slot  (rd_slot),
		.rd_light (rd_light),
		.mul_a    (mul_a),
		.mul_b    (mul_b),
		.mul_p    (mul_p),
		.done     (done),
		.res      (res)
	);

	assign place       = res.place;
	assign swap_count  = res.swaps;
	assign spill_key   = res.spill_key;
	assign spill_count = res.spill_count;
	assign light_value = res.light;

endmodule
